// ===== design/hsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hall six-step commutator package
// Shared item types, queue command type, constants and hall decode tables.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // Register indexes of the configuration port.
  localparam int CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] RegRotationDir  = 1'd0;
  localparam logic [CfgIndexW-1:0] RegSpeedPercent = 1'd1;
  localparam int CfgDataW = 8;

  // Duty mapping: 215 + floor(146 * p / 100), with p saturated to 100.
  // The division by 100 is a multiply by 146 * ceil(2^19 / 100) and a shift.
  localparam logic [8:0]  DutyBase     = 9'd215;
  localparam logic [7:0]  PercentMax   = 8'd100;
  localparam int          DutyProdW    = 27;
  localparam logic [26:0] DutyRecip    = 27'd765478;
  localparam int          DutyShift    = 19;

  // Speed measurement: 5000 / dt, saturating at a zero interval.
  localparam int          NumW         = 13;
  localparam logic [12:0] RpmNumerator = 13'd5000;
  localparam logic [15:0] RpmSaturated = 16'hFFFF;

  // Depth of the command queue between front and back.
  localparam int QueueDepth = 2;

  // What the back end does to the speed for one item.
  localparam logic [1:0] SpeedClear = 2'd0;
  localparam logic [1:0] SpeedHold  = 2'd1;
  localparam logic [1:0] SpeedSat   = 2'd2;
  localparam logic [1:0] SpeedDiv   = 2'd3;

  typedef struct packed {
    logic [2:0]  hall_code;
    logic [31:0] time_ms;
    logic        run_request;
  } sample_t;

  typedef struct packed {
    logic [8:0]  duty_a;
    logic [8:0]  duty_b;
    logic [8:0]  duty_c;
    logic        level_a;
    logic        level_b;
    logic        level_c;
    logic [15:0] speed_rpm;
    logic        running;
  } result_t;

  // Classified item as handed from the front end to the back end.
  typedef struct packed {
    logic [8:0]  duty_a;
    logic [8:0]  duty_b;
    logic [8:0]  duty_c;
    logic        level_a;
    logic        level_b;
    logic        level_c;
    logic        running;
    logic [1:0]  speed_kind;
    logic [31:0] dt;
  } cmd_t;

  // Driven phases per hall code (bit 0 A, bit 1 B, bit 2 C).
  function automatic logic [2:0] drive_mask(input logic [2:0] code);
    logic [2:0] m;
    case (code)
      3'b001:  m = 3'b101;
      3'b010:  m = 3'b011;
      3'b011:  m = 3'b110;
      3'b100:  m = 3'b110;
      3'b101:  m = 3'b011;
      3'b110:  m = 3'b101;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  // Clockwise levels of the driven phases per hall code.
  function automatic logic [2:0] cw_levels(input logic [2:0] code);
    logic [2:0] l;
    case (code)
      3'b001:  l = 3'b001;
      3'b010:  l = 3'b010;
      3'b011:  l = 3'b010;
      3'b100:  l = 3'b100;
      3'b101:  l = 3'b001;
      3'b110:  l = 3'b100;
      default: l = 3'b000;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== design/hsc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hall commutator front end
// Accepts hall items, decodes the commutation step, keeps duties, levels and
// the last timestamp, and hands a classified command to the queue.
// ----------------------------------------------------------------------------
module hsc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rotation_dir,
  input  wire logic [7:0]       speed_percent,
  input  wire logic             sample_valid,
  output logic                  sample_ready,
  input  wire hsc_pkg::sample_t sample,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output hsc_pkg::cmd_t         cmd
);

  logic [8:0]  duty [3];
  logic [2:0]  level;
  logic [31:0] last_time;

  logic [8:0]  duty_next [3];
  logic [2:0]  level_next;
  logic [31:0] last_time_next;
  logic [2:0]  mask;
  logic [2:0]  lv;
  logic [6:0]  pct;
  logic [26:0] prod;
  logic [8:0]  duty_on;
  logic [31:0] dt;
  logic [1:0]  kind;
  logic        accept;

  assign sample_ready = cmd_ready;
  assign cmd_valid    = sample_valid;
  assign accept       = sample_valid && cmd_ready;

  // Duty for the driven phases from the saturated percent.
  always_comb begin
    pct     = (speed_percent > hsc_pkg::PercentMax) ? hsc_pkg::PercentMax[6:0]
                                                    : speed_percent[6:0];
    prod    = hsc_pkg::DutyProdW'(pct) * hsc_pkg::DutyRecip;
    duty_on = hsc_pkg::DutyBase + 9'(prod >> hsc_pkg::DutyShift);
  end

  // Commutation step and speed classification.
  always_comb begin
    mask           = hsc_pkg::drive_mask(sample.hall_code);
    lv             = hsc_pkg::cw_levels(sample.hall_code) ^ (rotation_dir ? mask : 3'b000);
    level_next     = level;
    last_time_next = last_time;
    dt             = sample.time_ms - last_time;
    kind           = hsc_pkg::SpeedClear;
    for (int i = 0; i < 3; i++) begin
      duty_next[i] = duty[i];
    end
    if (!sample.run_request) begin
      for (int i = 0; i < 3; i++) begin
        duty_next[i] = 9'd0;
      end
    end else begin
      if (mask != 3'b000) begin
        for (int i = 0; i < 3; i++) begin
          duty_next[i] = mask[i] ? duty_on : 9'd0;
          if (mask[i]) begin
            level_next[i] = lv[i];
          end
        end
      end
      last_time_next = sample.time_ms;
      if (last_time == 32'd0) begin
        kind = hsc_pkg::SpeedHold;
      end else if (dt == 32'd0) begin
        kind = hsc_pkg::SpeedSat;
      end else begin
        kind = hsc_pkg::SpeedDiv;
      end
    end
  end

  // Command towards the back end.
  always_comb begin
    cmd.duty_a     = duty_next[0];
    cmd.duty_b     = duty_next[1];
    cmd.duty_c     = duty_next[2];
    cmd.level_a    = level_next[0];
    cmd.level_b    = level_next[1];
    cmd.level_c    = level_next[2];
    cmd.running    = sample.run_request;
    cmd.speed_kind = kind;
    cmd.dt         = dt;
  end

  // Commutation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        duty[i] <= 9'd0;
      end
      level     <= 3'b000;
      last_time <= 32'd0;
    end else if (accept) begin
      for (int i = 0; i < 3; i++) begin
        duty[i] <= duty_next[i];
      end
      level     <= level_next;
      last_time <= last_time_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/hsc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hall commutator command queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module hsc_queue #(
  parameter int DEPTH = hsc_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire hsc_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output hsc_pkg::cmd_t      pop_cmd
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  hsc_pkg::cmd_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/hsc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hall commutator back end
// Takes commands from the queue, works out the speed directly or with a serial
// divider and holds each result item in an output register.
// ----------------------------------------------------------------------------
module hsc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire hsc_pkg::cmd_t cmd,
  output logic               result_valid,
  input  wire logic          result_ready,
  output hsc_pkg::result_t   result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam int CntW = $clog2(hsc_pkg::NumW);

  logic [1:0]              state;
  hsc_pkg::cmd_t           held;
  logic [15:0]             speed_value;
  logic [hsc_pkg::NumW-1:0] rem;
  logic [hsc_pkg::NumW-1:0] quo;
  logic [hsc_pkg::NumW-1:0] num_sh;
  logic [CntW-1:0]         count;

  logic                    out_free;
  logic                    is_div;
  logic                    load;
  logic [hsc_pkg::NumW:0]  trial;
  logic                    fits;
  logic [hsc_pkg::NumW:0]  diff;
  logic [15:0]             speed_direct;

  assign out_free  = !result_valid || result_ready;
  assign is_div    = (cmd.speed_kind == hsc_pkg::SpeedDiv);
  assign cmd_ready = (state == ST_IDLE) && (is_div || out_free);

  // The output register takes a new item from a direct command or a finished division.
  assign load = ((state == ST_IDLE) && cmd_valid && cmd_ready && !is_div) ||
                ((state == ST_DONE) && out_free);

  // One restoring division step per cycle.
  always_comb begin
    trial = {rem, num_sh[hsc_pkg::NumW-1]};
    fits  = (32'(trial) >= held.dt);
    diff  = trial - held.dt[hsc_pkg::NumW:0];
  end

  // Speed for the items that need no division.
  always_comb begin
    case (cmd.speed_kind)
      hsc_pkg::SpeedClear: speed_direct = 16'd0;
      hsc_pkg::SpeedSat:   speed_direct = hsc_pkg::RpmSaturated;
      default:             speed_direct = speed_value;
    endcase
  end

  // Sequencer, divider and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      speed_value  <= 16'd0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            held <= cmd;
            if (is_div) begin
              rem    <= '0;
              quo    <= '0;
              num_sh <= hsc_pkg::RpmNumerator;
              count  <= CntW'(hsc_pkg::NumW - 1);
              state  <= ST_DIV;
            end else begin
              speed_value      <= speed_direct;
              result.duty_a    <= cmd.duty_a;
              result.duty_b    <= cmd.duty_b;
              result.duty_c    <= cmd.duty_c;
              result.level_a   <= cmd.level_a;
              result.level_b   <= cmd.level_b;
              result.level_c   <= cmd.level_c;
              result.speed_rpm <= speed_direct;
              result.running   <= cmd.running;
            end
          end
        end
        ST_DIV: begin
          rem    <= fits ? diff[hsc_pkg::NumW-1:0] : trial[hsc_pkg::NumW-1:0];
          quo    <= {quo[hsc_pkg::NumW-2:0], fits};
          num_sh <= {num_sh[hsc_pkg::NumW-2:0], 1'b0};
          count  <= count - 1'b1;
          if (count == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            speed_value      <= 16'(quo);
            result.duty_a    <= held.duty_a;
            result.duty_b    <= held.duty_b;
            result.duty_c    <= held.duty_c;
            result.level_a   <= held.level_a;
            result.level_b   <= held.level_b;
            result.level_c   <= held.level_c;
            result.speed_rpm <= 16'(quo);
            result.running   <= held.running;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/hall_six_step_commutator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hall six-step commutator
// Six-step BLDC commutation from hall codes, with speed measurement.
// ----------------------------------------------------------------------------
// Each hall item gives exactly one result item. The front end decodes an item
// in the cycle it is accepted and places it in a short command queue; the back
// end then takes one command at a time. An item that measures a new interval
// needs a 5000 / dt division, done by a serial divider one quotient bit per
// cycle: the back end takes the command, runs 13 division steps and then loads
// the output register once the output is free. Any other item is loaded into
// the output register as the back end takes it. The back end takes no new
// command until a division's result is loaded, so the divider sets the
// sustained throughput when every item measures speed, and the queue absorbs
// short bursts. Configuration writes are taken in every cycle.
module hall_six_step_commutator #(
  parameter int QUEUE_DEPTH = hsc_pkg::QueueDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hsc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [hsc_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                          sample_valid,
  output logic                               sample_ready,
  input  wire hsc_pkg::sample_t              sample,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output hsc_pkg::result_t                   result
);

  logic          rotation_dir;
  logic [7:0]    speed_percent;
  logic          fq_valid;
  logic          fq_ready;
  hsc_pkg::cmd_t fq_cmd;
  logic          qb_valid;
  logic          qb_ready;
  hsc_pkg::cmd_t qb_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_dir  <= 1'b0;
      speed_percent <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hsc_pkg::RegRotationDir:  rotation_dir  <= cfg_data[0];
        hsc_pkg::RegSpeedPercent: speed_percent <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  hsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .rotation_dir  (rotation_dir),
    .speed_percent (speed_percent),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .cmd_valid     (fq_valid),
    .cmd_ready     (fq_ready),
    .cmd           (fq_cmd)
  );

  hsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  hsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (qb_valid),
    .cmd_ready    (qb_ready),
    .cmd          (qb_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
